### hdl/crc_packet_fragmenter_assert.svh
// Assertion macros for the CRC packet fragmenter.
// Expects clk and rst_n in the scope of each use.
`ifndef CRC_PACKET_FRAGMENTER_ASSERT_SVH
`define CRC_PACKET_FRAGMENTER_ASSERT_SVH

// Condition must hold whenever the antecedent holds
`define CPF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Condition must never hold
`define CPF_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: assertion failed");

`endif

### hdl/cpf_pkg.sv
// Shared types, constants and the CRC step function of the packet fragmenter.
// No dependencies; imported by every module of the block.
`default_nettype none

package cpf_pkg;

  // Request commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // Configuration register indexes and address width
  localparam int unsigned CFG_AW   = 3;
  localparam logic        REG_DEST = 1'b0;
  localparam logic        REG_SRC  = 1'b1;

  // Packet constants
  localparam logic [7:0]  HDR_MARK       = 8'hAA;
  localparam logic [7:0]  STATUS_RESERVE = 8'h20;
  localparam logic [7:0]  STATUS_NONE    = 8'h00;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;

  // Job queue sizing
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // Output byte sequence steps within one job
  typedef logic [3:0] step_t;
  localparam step_t STEP_DATA        = 4'd0;
  localparam step_t STEP_HDR_MARK    = 4'd1;
  localparam step_t STEP_HDR_ROUTE   = 4'd2;
  localparam step_t STEP_HDR_ID      = 4'd3;
  localparam step_t STEP_HDR_LEN     = 4'd4;
  localparam step_t STEP_HDR_TOTAL   = 4'd5;
  localparam step_t STEP_HDR_SERIAL  = 4'd6;
  localparam step_t STEP_HDR_SERVICE = 4'd7;
  localparam step_t STEP_HDR_STATUS  = 4'd8;
  localparam step_t STEP_CRC_LO      = 4'd9;
  localparam step_t STEP_CRC_HI      = 4'd10;

  // One classified request: what the back end has to emit
  typedef struct packed {
    logic        has_data;
    logic        data_end;
    logic        has_hdr;
    logic        has_crc;
    logic [7:0]  data;
    logic [7:0]  hdr_len;
    logic [7:0]  serial;
    logic [7:0]  total;
    logic [7:0]  sync;
    logic [7:0]  service;
    logic        reserve;
    logic [15:0] crc;
  } job_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // CRC-16/CCITT-FALSE, one byte
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = {crc_in[7:0], crc_in[15:8]} ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/cpf_front.sv
// Front end: accepts requests, tracks message state, builds one job per request that it does not drop.
// Depends on cpf_pkg; feeds cpf_queue.
`default_nettype none

module cpf_front import cpf_pkg::*; #(
  parameter int MAX_CHUNK = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_msg_length,
  input  logic [7:0]  in_sync_id,
  input  logic [7:0]  in_service_id,
  input  logic        in_reserve,
  input  q_stat_t     q_stat,
  output logic        q_push,
  output job_t        q_job
);

  // Reciprocal for length / MAX_CHUNK; exact for 16-bit lengths and chunks below 256
  localparam logic [24:0] RECIP     = 25'((2**24 + MAX_CHUNK - 1) / MAX_CHUNK);
  localparam logic [7:0]  CHUNK_LEN = 8'(MAX_CHUNK);
  localparam logic [15:0] CHUNK_LIM = 16'(MAX_CHUNK);

  function automatic logic [7:0] chunk_len(input logic [15:0] left);
    logic [7:0] len;
    if (left < CHUNK_LIM) begin
      len = left[7:0] + 8'd2;
    end else begin
      len = CHUNK_LEN;
    end
    return len;
  endfunction

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic [7:0]  serial_r, serial_nxt;
  logic [7:0]  quo_r, quo_nxt;
  logic [7:0]  sync_r, sync_nxt;
  logic [7:0]  service_r, service_nxt;
  logic        reserve_r, reserve_nxt;
  logic        stg_vld_r, stg_vld_nxt;
  job_t        stg_r, stg_nxt;

  logic        accept;
  logic [15:0] crc_upd;
  logic [15:0] left_dec;
  logic [7:0]  fill_inc;
  logic        chunk_done;
  logic [40:0] prod;

  // Staged job leaves when the queue has room
  assign q_push   = stg_vld_r && !q_stat.full;
  assign in_ready = !stg_vld_r || !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign crc_upd    = crc_update(crc_r, in_data_byte);
  assign left_dec   = left_r - 16'd1;
  assign fill_inc   = fill_r + 8'd1;
  assign chunk_done = (fill_inc == CHUNK_LEN);
  assign prod       = 41'(in_msg_length) * 41'(RECIP);

  // Fill in the packet total from the quotient of the current message
  always_comb begin
    q_job       = stg_r;
    q_job.total = quo_r + 8'd1;
  end

  // Classify the request and advance message state
  always_comb begin
    crc_nxt     = crc_r;
    left_nxt    = left_r;
    fill_nxt    = fill_r;
    serial_nxt  = serial_r;
    quo_nxt     = quo_r;
    sync_nxt    = sync_r;
    service_nxt = service_r;
    reserve_nxt = reserve_r;
    stg_nxt     = stg_r;
    stg_vld_nxt = q_push ? 1'b0 : stg_vld_r;
    if (accept) begin
      if (in_command == CMD_START) begin
        crc_nxt          = CRC_INIT;
        left_nxt         = in_msg_length;
        fill_nxt         = 8'd0;
        serial_nxt       = 8'd1;
        quo_nxt          = prod[31:24];
        sync_nxt         = in_sync_id;
        service_nxt      = in_service_id;
        reserve_nxt      = in_reserve;
        stg_nxt          = '0;
        stg_nxt.has_hdr  = 1'b1;
        stg_nxt.has_crc  = (in_msg_length == 16'd0);
        stg_nxt.hdr_len  = chunk_len(in_msg_length);
        stg_nxt.serial   = 8'd1;
        stg_nxt.sync     = in_sync_id;
        stg_nxt.service  = in_service_id;
        stg_nxt.reserve  = in_reserve;
        stg_nxt.crc      = CRC_INIT;
        stg_vld_nxt      = 1'b1;
      end else if (left_r != 16'd0) begin
        // Payload byte of an open message; drop it otherwise
        crc_nxt          = crc_upd;
        left_nxt         = left_dec;
        fill_nxt         = chunk_done ? 8'd0 : fill_inc;
        serial_nxt       = chunk_done ? serial_r + 8'd1 : serial_r;
        stg_nxt          = '0;
        stg_nxt.has_data = 1'b1;
        stg_nxt.data     = in_data_byte;
        stg_nxt.data_end = chunk_done;
        stg_nxt.has_hdr  = chunk_done;
        stg_nxt.has_crc  = (left_dec == 16'd0);
        stg_nxt.hdr_len  = chunk_len(left_dec);
        stg_nxt.serial   = serial_r + 8'd1;
        stg_nxt.sync     = sync_r;
        stg_nxt.service  = service_r;
        stg_nxt.reserve  = reserve_r;
        stg_nxt.crc      = crc_upd;
        stg_vld_nxt      = 1'b1;
      end
    end
  end

  // Control and message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= CRC_INIT;
      left_r    <= 16'd0;
      fill_r    <= 8'd0;
      serial_r  <= 8'd0;
      quo_r     <= 8'd0;
      sync_r    <= 8'd0;
      service_r <= 8'd0;
      reserve_r <= 1'b0;
      stg_vld_r <= 1'b0;
    end else begin
      crc_r     <= crc_nxt;
      left_r    <= left_nxt;
      fill_r    <= fill_nxt;
      serial_r  <= serial_nxt;
      quo_r     <= quo_nxt;
      sync_r    <= sync_nxt;
      service_r <= service_nxt;
      reserve_r <= reserve_nxt;
      stg_vld_r <= stg_vld_nxt;
    end
  end

  // Staged job payload
  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

endmodule

`default_nettype wire

### hdl/cpf_queue.sv
// Job queue between front and back end, a few entries deep.
// Depends on cpf_pkg.
`default_nettype none

module cpf_queue import cpf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    din,
  input  logic    pop,
  output job_t    head,
  output q_stat_t q_stat
);

  job_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head         = ent_r[rd_r];
  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

  // Advance pointers and fill count
  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= din;
    end
  end

endmodule

`default_nettype wire

### hdl/cpf_back.sv
// Back end: expands the head job into stream bytes through an output register.
// Depends on cpf_pkg; reads jobs from cpf_queue.
`default_nettype none

module cpf_back import cpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  q_stat_t    q_stat,
  output logic       pop,
  input  logic [3:0] dest_id,
  input  logic [3:0] source_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_packet_start,
  output logic       out_packet_end,
  output logic       out_run_last
);

  logic       out_vld_r, out_vld_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       start_r, start_nxt;
  logic       end_r, end_nxt;
  logic       last_r, last_nxt;
  logic       busy_r, busy_nxt;
  step_t      step_r, step_nxt;

  logic  emit;
  step_t cur_step;
  step_t next_step;
  logic  job_last;

  assign emit = !q_stat.empty && (!out_vld_r || out_ready);
  assign pop  = emit && job_last;

  // Pick the step: first one of a fresh job, else the stored one
  always_comb begin
    if (busy_r) begin
      cur_step = step_r;
    end else if (head.has_data) begin
      cur_step = STEP_DATA;
    end else if (head.has_hdr) begin
      cur_step = STEP_HDR_MARK;
    end else begin
      cur_step = STEP_CRC_LO;
    end
  end

  // Find the following step and whether this byte closes the job
  always_comb begin
    next_step = cur_step + 4'd1;
    job_last  = 1'b0;
    if (cur_step == STEP_DATA) begin
      next_step = head.has_hdr ? STEP_HDR_MARK : STEP_CRC_LO;
      job_last  = !head.has_hdr && !head.has_crc;
    end else if (cur_step == STEP_HDR_STATUS) begin
      next_step = STEP_CRC_LO;
      job_last  = !head.has_crc;
    end else if (cur_step == STEP_CRC_HI) begin
      job_last  = 1'b1;
    end
  end

  // Select the stream byte for this step
  always_comb begin
    byte_nxt  = 8'h00;
    start_nxt = 1'b0;
    end_nxt   = 1'b0;
    unique case (cur_step)
      STEP_DATA: begin
        byte_nxt = head.data;
        end_nxt  = head.data_end;
      end
      STEP_HDR_MARK: begin
        byte_nxt  = HDR_MARK;
        start_nxt = 1'b1;
      end
      STEP_HDR_ROUTE:   byte_nxt = {dest_id, source_id};
      STEP_HDR_ID:      byte_nxt = head.sync;
      STEP_HDR_LEN:     byte_nxt = head.hdr_len;
      STEP_HDR_TOTAL:   byte_nxt = head.total;
      STEP_HDR_SERIAL:  byte_nxt = head.serial;
      STEP_HDR_SERVICE: byte_nxt = head.service;
      STEP_HDR_STATUS:  byte_nxt = head.reserve ? STATUS_RESERVE : STATUS_NONE;
      STEP_CRC_LO:      byte_nxt = head.crc[7:0];
      STEP_CRC_HI: begin
        byte_nxt = head.crc[15:8];
        end_nxt  = 1'b1;
      end
      default: byte_nxt = 8'h00;
    endcase
    last_nxt = job_last;
  end

  // Sequencer and output valid
  always_comb begin
    busy_nxt    = busy_r;
    step_nxt    = step_r;
    out_vld_nxt = out_vld_r && !out_ready;
    if (emit) begin
      busy_nxt    = !job_last;
      step_nxt    = next_step;
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      busy_r    <= 1'b0;
      step_r    <= STEP_DATA;
    end else begin
      out_vld_r <= out_vld_nxt;
      busy_r    <= busy_nxt;
      step_r    <= step_nxt;
    end
  end

  // Output payload register, loaded only when a byte is emitted
  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r  <= byte_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_out_byte     = byte_r;
  assign out_packet_start = start_r;
  assign out_packet_end   = end_r;
  assign out_run_last     = last_r;

endmodule

`default_nettype wire

### hdl/crc_packet_fragmenter.sv
// CRC packet fragmenter: turns a message into headed packets with a CRC-16 trailer.
// Usage
//   Input channel (in_valid/in_ready): a start request (command 0) carries the
//   message length, sync id, service id and reserve flag; byte requests
//   (command 1) carry payload. Bytes beyond the length, or with no message
//   open, are dropped and give no result.
//   Output channel (out_valid/out_ready): one stream byte per transfer, with
//   packet start/end marks and a flag on the last byte caused by a request.
//   APB port: dest_id at 0x0, source_id at 0x4; write only while idle.
// Timing
//   The first byte of a request passes the staging register, a queue entry and the output register in turn.
//   The output sequencer emits one byte per cycle while the queue holds a job
//   and out_ready allows it: a mid-chunk payload byte gives one byte (3 when
//   it ends the message), a start gives 8 (10 for an empty message), a byte
//   that closes a chunk gives 9 or 11. Long messages give about 1 + 8/MAX_CHUNK
//   stream bytes per payload byte plus 10 per message.
// Reset and stall
//   rst_n (synchronous, active low) clears message state, the job queue and
//   both registers. A stalled receiver holds the output register; the staging register and
//   the 4-deep job queue keep taking requests until both fill, then in_ready drops.
`default_nettype none

module crc_packet_fragmenter import cpf_pkg::*; #(
  parameter int MAX_CHUNK = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [7:0]        in_data_byte,
  input  logic [15:0]       in_msg_length,
  input  logic [7:0]        in_sync_id,
  input  logic [7:0]        in_service_id,
  input  logic              in_reserve,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_out_byte,
  output logic              out_packet_start,
  output logic              out_packet_end,
  output logic              out_run_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "crc_packet_fragmenter_assert.svh"

  logic [3:0] dest_r, dest_nxt;
  logic [3:0] src_r, src_nxt;
  logic       cfg_idx;
  logic       cfg_wr;

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  job_t    q_job;
  job_t    q_head;

  // Register access
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_AW-1];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    dest_nxt = dest_r;
    src_nxt  = src_r;
    prdata   = 32'd0;
    unique case (cfg_idx)
      REG_DEST: begin
        prdata = {28'd0, dest_r};
        if (cfg_wr) begin
          dest_nxt = pwdata[3:0];
        end
      end
      REG_SRC: begin
        prdata = {28'd0, src_r};
        if (cfg_wr) begin
          src_nxt = pwdata[3:0];
        end
      end
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= 4'd0;
      src_r  <= 4'd0;
    end else begin
      dest_r <= dest_nxt;
      src_r  <= src_nxt;
    end
  end

  cpf_front #(
    .MAX_CHUNK(MAX_CHUNK)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .in_msg_length(in_msg_length),
    .in_sync_id   (in_sync_id),
    .in_service_id(in_service_id),
    .in_reserve   (in_reserve),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  cpf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_job),
    .pop   (q_pop),
    .head  (q_head),
    .q_stat(q_stat)
  );

  cpf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .q_stat          (q_stat),
    .pop             (q_pop),
    .dest_id         (dest_r),
    .source_id       (src_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_out_byte    (out_out_byte),
    .out_packet_start(out_packet_start),
    .out_packet_end  (out_packet_end),
    .out_run_last    (out_run_last)
  );

  // Queue never written full or read empty; a packet mark byte never ends a packet
  `CPF_ASSERT_NEVER(a_q_no_overflow, q_push && q_stat.full)
  `CPF_ASSERT_NEVER(a_q_no_underflow, q_pop && q_stat.empty)
  `CPF_ASSERT_IMPL(a_mark_byte, out_valid && out_packet_start, (out_out_byte == HDR_MARK) && !out_packet_end)

endmodule

`default_nettype wire
